>>> rtl/gaussian_window_blur_top_assert.svh
// Assertion macros shared by the Gaussian window blur RTL.
`ifndef GAUSSIAN_WINDOW_BLUR_TOP_ASSERT_SVH
`define GAUSSIAN_WINDOW_BLUR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GWB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GWB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gwb_pkg.sv
// Shared constants, weight tables and types of the Gaussian window blur.
package gwb_pkg;

  localparam int RADIUS           = 5;
  localparam int MAX_WIDTH        = 1024;
  localparam int WEIGHT_FRAC_BITS = 15;
  localparam int HEIGHT_LIMIT     = 4096;

  localparam int SLOTS  = 3 * RADIUS + 1;
  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int SUM_N  = 4 * RADIUS + 1;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int WCFG_W  = 11;
  localparam int HCFG_W  = 13;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 24;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int JW      = $clog2(TAPS);
  localparam int SUM_W   = $clog2(SUM_N);
  localparam int WW      = WEIGHT_FRAC_BITS + 1;
  localparam int MEM_DEPTH = SLOTS * (1 << COL_W);
  localparam int MEM_AW  = $clog2(MEM_DEPTH);

  // register indexes and op codes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // 1-D Gaussian, FWHM 5, Q1.15
  localparam int unsigned GAUSS_Q15 [8] = '{
    32768, 29331, 21035, 12086, 5564, 2052, 606, 144
  };

  typedef logic [WW-1:0] wt_tab_t [SUM_N];

  typedef struct packed {
    logic          adv;
    logic [WW-1:0] wt;
  } cell_ctl_t;

  // rescale a Q1.15 entry to Q1.WEIGHT_FRAC_BITS, rounding half up
  function automatic logic [WW-1:0] weight_of(input int d);
    longint unsigned t;
    int up;
    int down;
    up   = (WEIGHT_FRAC_BITS >= 15) ? WEIGHT_FRAC_BITS - 15 : 0;
    down = (WEIGHT_FRAC_BITS < 15) ? 15 - WEIGHT_FRAC_BITS : 0;
    t = longint'(GAUSS_Q15[d & 7]) << up;
    if (down > 0) begin
      t = (t + (64'd1 << (down - 1))) >> down;
    end
    return WW'(t);
  endfunction

  // weight by row index plus column index, both counted from the window corner
  function automatic wt_tab_t build_wt_tab();
    wt_tab_t tab;
    int k;
    for (int s = 0; s < SUM_N; s++) begin
      k = (s - 2 * RADIUS) / 2;
      tab[s] = weight_of((k < 0) ? -k : k);
    end
    return tab;
  endfunction

  localparam wt_tab_t WT_BY_SUM = build_wt_tab();

  function automatic longint unsigned norm_sum();
    longint unsigned acc;
    acc = 0;
    for (int jj = 0; jj < TAPS; jj++) begin
      for (int ii = 0; ii < TAPS; ii++) begin
        acc = acc + longint'(WT_BY_SUM[jj + ii]);
      end
    end
    return acc;
  endfunction

  localparam longint unsigned NORM  = norm_sum();
  localparam int              SHIFT = 24 + WEIGHT_FRAC_BITS;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + NORM / 2) / NORM;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int TOT_W   = $clog2(NORM * 255 + 1);
  localparam int PROD_W  = TOT_W + RECIP_W;

endpackage

>>> rtl/gwb_line_mem.sv
// Line store: row slots of pixels, one write and one registered read per cycle.
module gwb_line_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [gwb_pkg::MEM_AW-1:0]   wr_addr,
  input  logic [gwb_pkg::PIX_W-1:0]    wr_data,
  input  logic [gwb_pkg::MEM_AW-1:0]   rd_addr,
  output logic [gwb_pkg::PIX_W-1:0]    rd_data
);

  logic [gwb_pkg::PIX_W-1:0] mem [gwb_pkg::MEM_DEPTH];
  logic [gwb_pkg::PIX_W-1:0] rd_data_r;

  // write incoming pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read tap pixel
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/gwb_tap_cell.sv
// One tap cell of the transposed weighted-sum chain.
module gwb_tap_cell (
  input  logic                        clk,
  input  gwb_pkg::cell_ctl_t          ctl,
  input  logic [gwb_pkg::PIX_W-1:0]   pix_in,
  input  logic [gwb_pkg::TOT_W-1:0]   acc_in,
  output logic [gwb_pkg::TOT_W-1:0]   acc_out
);

  logic [gwb_pkg::PIX_W+gwb_pkg::WW-1:0] mul;
  logic [gwb_pkg::TOT_W-1:0]             acc_r;

  assign mul = pix_in * ctl.wt;

  // add own product to the neighbor's partial sum
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      acc_r <= acc_in + gwb_pkg::TOT_W'(mul);
    end
  end

  assign acc_out = acc_r;

endmodule

>>> rtl/gaussian_window_blur_top.sv
// Top level of the Gaussian window blur: control, counters, tap chain and scaling.
`include "gaussian_window_blur_top_assert.svh"

// Streaming 2-D Gaussian blur of 8-bit grey pixels in raster order, with edge
// clamping and an 11x11 window. Each output pixel is emitted once its window
// is complete, R rows and R pixels behind the input; drain words flush the tail.
// For a word that produces a result, the window taps are read one per cycle
// from the single read port of the line store and fed through a chain of 2R+1
// multiply-add cells. A new input word is taken while the last result still
// waits in the output register. The line store needs no clearing after reset.
// Writing a register restarts the frame.
module gaussian_window_blur_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel_in
  input  logic                          in_tuser,   // [0] op
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [7:0] pixel_out, [19:8] out_row,
                                                    // [29:20] out_col, [31:30] zero
  output logic                          out_tlast,  // frame_last
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [gwb_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int R  = gwb_pkg::RADIUS;
  localparam int TP = gwb_pkg::TAPS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [gwb_pkg::WCFG_W-1:0] cfg_w_r, w_eff;
  logic [gwb_pkg::HCFG_W-1:0] cfg_h_r, h_eff;
  logic [gwb_pkg::IDX_W-1:0]  tot_r, have, need_raw, need;

  logic [gwb_pkg::COL_W-1:0]  in_col_r, out_col_r;
  logic [gwb_pkg::ROW_W-1:0]  in_row_r, out_row_r;
  logic [gwb_pkg::SLOT_W-1:0] in_slot_r, out_slot_r;
  logic [gwb_pkg::IDX_W-1:0]  in_idx_r, out_idx_r;
  logic                       in_done_r;

  logic [gwb_pkg::COL_W-1:0]  lx_r, lx0_r, lx0;
  logic [gwb_pkg::ROW_W-1:0]  ly_r, ly0;
  logic [gwb_pkg::SLOT_W-1:0] rslot_r, rslot0;
  logic [gwb_pkg::JW-1:0]     ic_r, jc_r;
  logic                       last_col, last_row;

  logic                       rd_vld_r, rd_lcol_r, rd_fin_r, row_end_r, fin2_r, sum_fin_r;
  logic [gwb_pkg::JW-1:0]     rd_jj_r;
  logic [gwb_pkg::PIX_W-1:0]  rd_pix;

  logic [gwb_pkg::TOT_W-1:0]  cell_acc [TP];
  logic [gwb_pkg::TOT_W-1:0]  tot_acc_r;
  logic [gwb_pkg::PROD_W-1:0] prod_r;
  logic [gwb_pkg::PIX_W-1:0]  pix_res;

  logic accept, pix_wr, go, emit, frame_last, cnt_clr;
  logic [gwb_pkg::MEM_AW-1:0] wr_addr, rd_addr;

  logic        out_tvalid_r, out_tlast_r;
  logic [31:0] out_tdata_r;

  // effective frame size
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = gwb_pkg::WCFG_W'(1);
    end else if (cfg_w_r > gwb_pkg::WCFG_W'(gwb_pkg::MAX_WIDTH)) begin
      w_eff = gwb_pkg::WCFG_W'(gwb_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      h_eff = gwb_pkg::HCFG_W'(1);
    end else if (cfg_h_r > gwb_pkg::HCFG_W'(gwb_pkg::HEIGHT_LIMIT)) begin
      h_eff = gwb_pkg::HCFG_W'(gwb_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = cfg_h_r;
    end
  end

  // frame pixel count
  always_ff @(posedge clk) begin
    tot_r <= gwb_pkg::IDX_W'(w_eff) * gwb_pkg::IDX_W'(h_eff);
  end

  // readiness of the next output pixel
  assign have     = in_done_r ? tot_r : in_idx_r;
  assign need_raw = out_idx_r + gwb_pkg::IDX_W'(w_eff) * gwb_pkg::IDX_W'(R)
                    + gwb_pkg::IDX_W'(R + 1);
  assign need     = (need_raw > tot_r) ? tot_r : need_raw;
  assign go       = (have >= need);

  assign accept     = in_tvalid && in_tready;
  assign pix_wr     = accept && (in_tuser == gwb_pkg::OP_PIXEL) && !in_done_r;
  assign emit       = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign frame_last = (out_idx_r == tot_r - gwb_pkg::IDX_W'(1));
  assign cnt_clr    = cfg_we || (emit && frame_last);

  // window start, clamped to the top and left edges
  assign lx0 = (out_col_r >= gwb_pkg::COL_W'(R)) ? out_col_r - gwb_pkg::COL_W'(R) : '0;
  assign ly0 = (out_row_r >= gwb_pkg::ROW_W'(R)) ? out_row_r - gwb_pkg::ROW_W'(R) : '0;
  always_comb begin
    if (out_row_r < gwb_pkg::ROW_W'(R)) begin
      rslot0 = '0;
    end else if (out_slot_r >= gwb_pkg::SLOT_W'(R)) begin
      rslot0 = out_slot_r - gwb_pkg::SLOT_W'(R);
    end else begin
      rslot0 = out_slot_r + gwb_pkg::SLOT_W'(gwb_pkg::SLOTS - R);
    end
  end

  assign last_col = (ic_r == gwb_pkg::JW'(TP - 1));
  assign last_row = (jc_r == gwb_pkg::JW'(TP - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = go ? ST_RUN : ST_IDLE;
      ST_RUN:   if (last_col && last_row) state_nxt = ST_WAIT;
      ST_WAIT:  if (sum_fin_r) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT:  if (emit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // control state: fsm, registers, frame counters, read pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_w_r      <= gwb_pkg::WCFG_W'(1024);
      cfg_h_r      <= gwb_pkg::HCFG_W'(1024);
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      in_idx_r     <= '0;
      in_done_r    <= 1'b0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_slot_r   <= '0;
      out_idx_r    <= '0;
      rd_vld_r     <= 1'b0;
      rd_fin_r     <= 1'b0;
      row_end_r    <= 1'b0;
      fin2_r       <= 1'b0;
      sum_fin_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        if (cfg_addr == gwb_pkg::CFG_IDX_WIDTH) begin
          cfg_w_r <= cfg_wdata[gwb_pkg::WCFG_W-1:0];
        end else begin
          cfg_h_r <= cfg_wdata[gwb_pkg::HCFG_W-1:0];
        end
      end

      // frame counters
      if (cnt_clr) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        in_slot_r  <= '0;
        in_idx_r   <= '0;
        in_done_r  <= 1'b0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_slot_r <= '0;
        out_idx_r  <= '0;
      end else begin
        if (pix_wr) begin
          if ({1'b0, in_col_r} + gwb_pkg::WCFG_W'(1) >= w_eff) begin
            in_col_r <= '0;
            if ({1'b0, in_row_r} + gwb_pkg::HCFG_W'(1) >= h_eff) begin
              in_row_r  <= '0;
              in_slot_r <= '0;
              in_idx_r  <= '0;
              in_done_r <= 1'b1;
            end else begin
              in_row_r  <= in_row_r + 1'b1;
              in_slot_r <= (in_slot_r == gwb_pkg::SLOT_W'(gwb_pkg::SLOTS - 1)) ?
                           '0 : in_slot_r + 1'b1;
              in_idx_r  <= in_idx_r + 1'b1;
            end
          end else begin
            in_col_r <= in_col_r + 1'b1;
            in_idx_r <= in_idx_r + 1'b1;
          end
        end
        if (emit) begin
          out_idx_r <= out_idx_r + 1'b1;
          if ({1'b0, out_col_r} + gwb_pkg::WCFG_W'(1) >= w_eff) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_slot_r <= (out_slot_r == gwb_pkg::SLOT_W'(gwb_pkg::SLOTS - 1)) ?
                          '0 : out_slot_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end

      // read pipeline flags
      rd_vld_r  <= (state_r == ST_RUN);
      rd_fin_r  <= (state_r == ST_RUN) && last_col && last_row;
      row_end_r <= rd_vld_r && rd_lcol_r;
      fin2_r    <= rd_fin_r;
      sum_fin_r <= fin2_r;

      // output register
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // window walk: rows top to bottom, columns left to right, clamped at every edge;
  // hold on the top row or left column until the tap position enters the image
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      lx_r    <= lx0;
      lx0_r   <= lx0;
      ly_r    <= ly0;
      rslot_r <= rslot0;
      ic_r    <= '0;
      jc_r    <= '0;
    end else if (state_r == ST_RUN) begin
      if (last_col) begin
        ic_r <= '0;
        jc_r <= jc_r + 1'b1;
        lx_r <= lx0_r;
        if (({1'b0, out_row_r} + gwb_pkg::HCFG_W'(jc_r) >= gwb_pkg::HCFG_W'(R)) &&
            ({1'b0, ly_r} < h_eff - gwb_pkg::HCFG_W'(1))) begin
          ly_r    <= ly_r + 1'b1;
          rslot_r <= (rslot_r == gwb_pkg::SLOT_W'(gwb_pkg::SLOTS - 1)) ?
                     '0 : rslot_r + 1'b1;
        end
      end else begin
        ic_r <= ic_r + 1'b1;
        if (({1'b0, out_col_r} + gwb_pkg::WCFG_W'(ic_r) >= gwb_pkg::WCFG_W'(R)) &&
            ({1'b0, lx_r} < w_eff - gwb_pkg::WCFG_W'(1))) begin
          lx_r <= lx_r + 1'b1;
        end
      end
    end
    rd_jj_r   <= jc_r;
    rd_lcol_r <= last_col;
  end

  assign wr_addr = {in_slot_r, in_col_r};
  assign rd_addr = {rslot_r, lx_r};

  gwb_line_mem u_line_mem (
    .clk     (clk),
    .wr_en   (pix_wr),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_pix)
  );

  // tap chain: cell k weighs the pixel at column offset R-k of the current row
  for (genvar k = 0; k < TP; k++) begin : g_cell
    gwb_pkg::cell_ctl_t          ctl;
    logic [gwb_pkg::TOT_W-1:0]   acc_in;
    assign ctl.adv = rd_vld_r;
    assign ctl.wt  = gwb_pkg::WT_BY_SUM[gwb_pkg::SUM_W'(rd_jj_r)
                                        + gwb_pkg::SUM_W'(2 * R - k)];
    if (k == TP - 1) begin : g_end
      assign acc_in = '0;
    end else begin : g_mid
      assign acc_in = cell_acc[k + 1];
    end
    gwb_tap_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pix_in  (rd_pix),
      .acc_in  (acc_in),
      .acc_out (cell_acc[k])
    );
  end

  // sum the row totals, then scale by the reciprocal of the weight sum
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      tot_acc_r <= '0;
    end else if (row_end_r) begin
      tot_acc_r <= tot_acc_r + cell_acc[0];
    end
    if (state_r == ST_MUL) begin
      prod_r <= gwb_pkg::PROD_W'(tot_acc_r) * gwb_pkg::PROD_W'(gwb_pkg::RECIP);
    end
  end

  assign pix_res = (prod_r[gwb_pkg::PROD_W-1:gwb_pkg::SHIFT] >
                    (gwb_pkg::PROD_W - gwb_pkg::SHIFT)'(255)) ?
                   8'hFF : prod_r[gwb_pkg::SHIFT +: 8];

  // load the result word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= {2'b00, out_col_r, out_row_r, pix_res};
      out_tlast_r <= frame_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `GWB_ASSERT_NXT(a_rd_from_run, state_r == ST_RUN, rd_vld_r, "tap read without walk")
  `GWB_ASSERT_NXT(a_acc_clear, state_r == ST_CHECK && go, tot_acc_r == '0, "sum not cleared")
  `GWB_ASSERT_IMP(a_mul_after_sum, state_r == ST_MUL, $past(sum_fin_r), "scale before sum")
  `GWB_ASSERT_IMP(a_col_bound, 1'b1,
                  ({1'b0, out_col_r} < w_eff) && ({1'b0, in_col_r} < w_eff),
                  "column counter past width")

endmodule

>>> tb/sv/gaussian_window_blur_top_test.sv
// Self-checking testbench for the Gaussian window blur top level.
`timescale 1ns / 100ps

module gaussian_window_blur_top_test;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  TAIL_CYCLES = 400;
  localparam int  BLUR_SHIFT  = 39;
  localparam int  ITEM_GOAL   = 1600;

  typedef struct {
    logic       op;
    logic [7:0] pix;
    bit         hold;
  } pix_word_t;

  typedef struct {
    logic [7:0]  pix;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } blur_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [gwb_pkg::CFG_W-1:0] cfg_wdata;

  gaussian_window_blur_top DUT (.*);

  // stimulus and expected pixels
  pix_word_t pend_words[$];
  blur_res_t blur_expq[$];
  pix_word_t cur_word;
  bit        word_taken;
  bit        calm;
  int        in_gap;
  int        out_stall;
  int        errors;
  int        cycles;
  int        items_sent;

  // shadow copy of the block's state
  bit [7:0]  shadow_lines[gwb_pkg::SLOTS * gwb_pkg::MAX_WIDTH];
  int unsigned sh_width, sh_height;
  int unsigned sh_in_row, sh_in_col, sh_out_row, sh_out_col;
  bit        sh_in_done;
  longint unsigned gauss_wt[8] = '{32768, 29331, 21035, 12086, 5564, 2052, 606, 144};

  function automatic int unsigned active_width();
    if (sh_width < 1) return 1;
    if (sh_width > gwb_pkg::MAX_WIDTH) return gwb_pkg::MAX_WIDTH;
    return sh_width;
  endfunction

  function automatic int unsigned active_height();
    if (sh_height < 1) return 1;
    if (sh_height > gwb_pkg::HEIGHT_LIMIT) return gwb_pkg::HEIGHT_LIMIT;
    return sh_height;
  endfunction

  function automatic void restart_frame();
    sh_in_row = 0;
    sh_in_col = 0;
    sh_out_row = 0;
    sh_out_col = 0;
    sh_in_done = 0;
  endfunction

  // advance the shadow state by one word, queue the blurred pixel it releases
  function automatic void blur_predict(logic op, logic [7:0] pix);
    int unsigned w, h, total, have, pos, need;
    longint unsigned acc, norm, recip, v, wt;
    int ly, lx, k;
    blur_res_t r;
    w = active_width();
    h = active_height();
    total = w * h;
    if (op == gwb_pkg::OP_PIXEL && !sh_in_done) begin
      shadow_lines[(sh_in_row % gwb_pkg::SLOTS) * gwb_pkg::MAX_WIDTH + sh_in_col] = pix;
      sh_in_col++;
      if (sh_in_col >= w) begin
        sh_in_col = 0;
        sh_in_row++;
        if (sh_in_row >= h) begin
          sh_in_row = 0;
          sh_in_done = 1;
        end
      end
    end
    have = sh_in_done ? total : sh_in_row * w + sh_in_col;
    pos = sh_out_row * w + sh_out_col;
    need = pos + gwb_pkg::RADIUS * w + gwb_pkg::RADIUS + 1;
    if (need > total) need = total;
    if (have < need) return;
    acc = 0;
    norm = 0;
    for (int j = -gwb_pkg::RADIUS; j <= gwb_pkg::RADIUS; j++) begin
      ly = int'(sh_out_row) + j;
      if (ly < 0) ly = 0;
      if (ly > int'(h) - 1) ly = int'(h) - 1;
      for (int i = -gwb_pkg::RADIUS; i <= gwb_pkg::RADIUS; i++) begin
        lx = int'(sh_out_col) + i;
        if (lx < 0) lx = 0;
        if (lx > int'(w) - 1) lx = int'(w) - 1;
        k = (j + i) / 2;
        wt = gauss_wt[(k < 0) ? -k : k];
        acc += longint'(shadow_lines[(ly % gwb_pkg::SLOTS) * gwb_pkg::MAX_WIDTH + lx]) * wt;
        norm += wt;
      end
    end
    recip = ((64'd1 << BLUR_SHIFT) + norm / 2) / norm;
    v = (acc * recip) >> BLUR_SHIFT;
    if (v > 255) v = 255;
    r.pix = v[7:0];
    r.row = sh_out_row[11:0];
    r.col = sh_out_col[9:0];
    r.last = (pos == total - 1);
    blur_expq.push_back(r);
    if (r.last) begin
      restart_frame();
    end else begin
      sh_out_col++;
      if (sh_out_col >= w) begin
        sh_out_col = 0;
        sh_out_row++;
      end
    end
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // drive input words, honoring random gaps and the hold marker
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (in_tvalid && !word_taken) begin
      in_tvalid <= 1;
    end else begin
      word_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (pend_words.size() > 0 &&
                   (!pend_words[0].hold || blur_expq.size() == 0)) begin
        cur_word = pend_words.pop_front();
        in_tdata <= cur_word.pix;
        in_tuser <= cur_word.op;
        in_tvalid <= 1;
        in_gap = calm ? 0 : $urandom_range(0, 17);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // drive ready with random stalls per word
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // check results, then predict from the accepted input word
  always @(posedge clk) begin
    blur_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gaussian_window_blur_top regression: fail");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_stall = calm ? 0 : $urandom_range(0, 17);
        if (blur_expq.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h last %b", out_tdata, out_tlast);
        end else begin
          e = blur_expq.pop_front();
          if (out_tdata !== {2'b00, e.col, e.row, e.pix} || out_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp pix %0d row %0d col %0d last %b, got %0d %0d %0d %b",
                       e.pix, e.row, e.col, e.last, out_tdata[7:0], out_tdata[19:8],
                       out_tdata[29:20], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        word_taken = 1;
        blur_predict(cur_word.op, cur_word.pix);
      end
    end
  end

  task automatic push_word(logic op, logic [7:0] pix, bit hold = 0);
    pix_word_t p;
    p.op = op;
    p.pix = pix;
    p.hold = hold;
    pend_words.push_back(p);
    items_sent++;
  endtask

  // wait for all words sent and results seen, plus the block's latency
  task automatic settle();
    while (pend_words.size() > 0 || in_tvalid || blur_expq.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [gwb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == gwb_pkg::CFG_IDX_WIDTH) sh_width = {21'd0, val[10:0]};
    else sh_height = {19'd0, val};
    restart_frame();
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // a frame with noise, sometimes cut short; a full frame is flushed by drain words
  task automatic run_frame(int unsigned w, int unsigned h, bit stray, bit pause);
    int unsigned n;
    bit cut;
    n = w * h;
    cut = ($urandom_range(0, 7) == 0);
    if (cut) n = $urandom_range(1, n);
    if ($urandom_range(0, 1)) push_word(gwb_pkg::OP_DRAIN, pick_pixel());
    for (int unsigned p = 0; p < n; p++) begin
      if ($urandom_range(0, 15) == 0) push_word(gwb_pkg::OP_DRAIN, pick_pixel());
      push_word(gwb_pkg::OP_PIXEL, pick_pixel(), pause && p == n / 2);
    end
    if (!cut) begin
      if (stray) push_word(gwb_pkg::OP_PIXEL, pick_pixel());
      for (int unsigned d = 0; d < gwb_pkg::RADIUS * w + gwb_pkg::RADIUS + 2; d++)
        push_word(gwb_pkg::OP_DRAIN, pick_pixel());
    end
  endtask

  initial begin
    int unsigned w, h;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = 0;
    cfg_wdata = 0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    in_gap = 0;
    out_stall = 0;
    word_taken = 0;
    calm = 0;
    sh_width = 1024;
    sh_height = 1024;
    restart_frame();
    repeat (6) @(negedge clk);
    rst_n <= 1;

    // reset geometry: drains before data, then a few extreme pixels
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    push_word(gwb_pkg::OP_DRAIN, 8'd255);
    push_word(gwb_pkg::OP_PIXEL, 8'd0);
    push_word(gwb_pkg::OP_PIXEL, 8'd255);
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    settle();

    // single pixel frame, pixel after completion, then drain
    write_reg(gwb_pkg::CFG_IDX_WIDTH, 13'd1);
    write_reg(gwb_pkg::CFG_IDX_HEIGHT, 13'd1);
    push_word(gwb_pkg::OP_PIXEL, 8'd255);
    push_word(gwb_pkg::OP_PIXEL, 8'd0);
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    settle();

    // zero geometry saturates to one
    write_reg(gwb_pkg::CFG_IDX_WIDTH, 13'd0);
    write_reg(gwb_pkg::CFG_IDX_HEIGHT, 13'd0);
    push_word(gwb_pkg::OP_PIXEL, 8'd128);
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    settle();

    // small frame with alternating extremes
    write_reg(gwb_pkg::CFG_IDX_WIDTH, 13'd3);
    write_reg(gwb_pkg::CFG_IDX_HEIGHT, 13'd2);
    for (int p = 0; p < 6; p++) push_word(gwb_pkg::OP_PIXEL, p[0] ? 8'd255 : 8'd0);
    push_word(gwb_pkg::OP_PIXEL, 8'd77);
    for (int d = 0; d < 4; d++) push_word(gwb_pkg::OP_DRAIN, 8'd0);
    settle();

    // oversize geometry saturates; a few pixels in, then abort with a one-row frame
    // at full width, pausing the sender until the pending results are back
    calm = 1;
    write_reg(gwb_pkg::CFG_IDX_WIDTH, 13'h7FF);
    write_reg(gwb_pkg::CFG_IDX_HEIGHT, 13'h1FFF);
    for (int p = 0; p < 30; p++) push_word(gwb_pkg::OP_PIXEL, pick_pixel());
    settle();
    write_reg(gwb_pkg::CFG_IDX_HEIGHT, 13'd1);
    for (int p = 0; p < gwb_pkg::MAX_WIDTH; p++) push_word(gwb_pkg::OP_PIXEL, pick_pixel());
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    push_word(gwb_pkg::OP_DRAIN, 8'd0, 1);
    push_word(gwb_pkg::OP_DRAIN, 8'd0);
    settle();
    calm = 0;

    // random frames, mostly small
    while (items_sent < ITEM_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 16);
      h = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 10);
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0 || w != active_width())
        write_reg(gwb_pkg::CFG_IDX_WIDTH, gwb_pkg::CFG_W'(w));
      write_reg(gwb_pkg::CFG_IDX_HEIGHT, gwb_pkg::CFG_W'(h));
      run_frame(w, h, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) run_frame(w, h, 0, 0);
      settle();
    end

    if (errors == 0) begin
      $display("gaussian_window_blur_top regression: pass");
    end else begin
      $display("gaussian_window_blur_top regression: fail");
    end
    $finish;
  end

endmodule
